/* hw/rtl/aabb_pkg.sv */
// Shared types and constants for the bounding box transform block.
// No dependencies; imported by the lane, the merge, the top level and the testbench.
`default_nettype none

package aabb_pkg;

    localparam int NUM_ROWS = 3;
    localparam int NUM_COLS = 3;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_BOX  = 1'b1;

    typedef struct packed {
        logic adv1;
        logic adv2;
    } pipe_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/aabb_if.sv */
// Request and response channel interfaces with valid/ready handshake.
// No dependencies; used by the top level and its environment.
`default_nettype none

interface aabb_req_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic                func;
    logic [1:0]          row;
    logic signed [W-1:0] val0;
    logic signed [W-1:0] val1;
    logic signed [W-1:0] val2;
    logic signed [W-1:0] val3;
    logic signed [W-1:0] val4;
    logic signed [W-1:0] val5;

    modport source (
        output valid, func, row, val0, val1, val2, val3, val4, val5,
        input  ready
    );

    modport sink (
        input  valid, func, row, val0, val1, val2, val3, val4, val5,
        output ready
    );
endinterface

interface aabb_rsp_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] out_min_x;
    logic signed [W-1:0] out_min_y;
    logic signed [W-1:0] out_min_z;
    logic signed [W-1:0] out_max_x;
    logic signed [W-1:0] out_max_y;
    logic signed [W-1:0] out_max_z;
    logic                saturated;

    modport source (
        output valid, out_min_x, out_min_y, out_min_z,
               out_max_x, out_max_y, out_max_z, saturated,
        input  ready
    );

    modport sink (
        input  valid, out_min_x, out_min_y, out_min_z,
               out_max_x, out_max_y, out_max_z, saturated,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/aabb_lane.sv */
// One matrix row lane: six products, min/max per column, accumulation.
// Depends on aabb_pkg.
`default_nettype none

module aabb_lane
    import aabb_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic                  clk,
    input  wire pipe_ctl_t             ctl,
    input  wire logic signed [W-1:0]   coef [NUM_COLS],
    input  wire logic signed [W-1:0]   trans,
    input  wire logic signed [W-1:0]   lo [NUM_COLS],
    input  wire logic signed [W-1:0]   hi [NUM_COLS],
    output logic signed [2*W+1:0]      acc_min,
    output logic signed [2*W+1:0]      acc_max
);

    localparam int PW = 2 * W;
    localparam int AW = 2 * W + 2;

    logic signed [PW-1:0] prod_lo_reg [NUM_COLS];
    logic signed [PW-1:0] prod_hi_reg [NUM_COLS];
    logic signed [W-1:0]  trans_reg;
    logic signed [PW-1:0] lesser [NUM_COLS];
    logic signed [PW-1:0] greater [NUM_COLS];
    logic signed [AW-1:0] sum_min_next;
    logic signed [AW-1:0] sum_max_next;
    logic signed [AW-1:0] acc_min_reg;
    logic signed [AW-1:0] acc_max_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.adv1)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                prod_lo_reg[c] <= PW'(coef[c]) * PW'(lo[c]);
                prod_hi_reg[c] <= PW'(coef[c]) * PW'(hi[c]);
            end
            trans_reg <= trans;
        end
    end

    always_comb
    begin
        sum_min_next = AW'(trans_reg) <<< F;
        sum_max_next = AW'(trans_reg) <<< F;
        for (int c = 0; c < NUM_COLS; c++)
        begin
            if (prod_hi_reg[c] < prod_lo_reg[c])
            begin
                lesser[c]  = prod_hi_reg[c];
                greater[c] = prod_lo_reg[c];
            end
            else
            begin
                lesser[c]  = prod_lo_reg[c];
                greater[c] = prod_hi_reg[c];
            end
            sum_min_next = sum_min_next + AW'(lesser[c]);
            sum_max_next = sum_max_next + AW'(greater[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv2)
        begin
            acc_min_reg <= sum_min_next;
            acc_max_reg <= sum_max_next;
        end
    end

    assign acc_min = acc_min_reg;
    assign acc_max = acc_max_reg;

endmodule

`default_nettype wire

/* hw/rtl/aabb_merge.sv */
// Merge stage: rescale and saturate the lane sums, gather the flag, hold the response.
// Depends on aabb_pkg and aabb_rsp_if.
`default_nettype none

module aabb_merge
    import aabb_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic signed [2*W+1:0] acc_min [NUM_ROWS],
    input  wire logic signed [2*W+1:0] acc_max [NUM_ROWS],
    output logic                      adv,
    aabb_rsp_if.source                rsp
);

    localparam int AW = 2 * W + 2;

    logic                valid_reg;
    logic signed [W-1:0] min_reg [NUM_ROWS];
    logic signed [W-1:0] max_reg [NUM_ROWS];
    logic                sat_reg;
    logic [W:0]          fin_min [NUM_ROWS];
    logic [W:0]          fin_max [NUM_ROWS];
    logic                sat_next;

    function automatic logic [W:0] finish(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] s;
        logic [W:0]           r;
        s = a >>> F;
        if (s[AW-1:W-1] == {(AW-W+1){s[AW-1]}})
            r = {1'b0, s[W-1:0]};
        else if (s[AW-1])
            r = {1'b1, 1'b1, {(W-1){1'b0}}};
        else
            r = {1'b1, 1'b0, {(W-1){1'b1}}};
        return r;
    endfunction

    always_comb
    begin
        sat_next = 1'b0;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            fin_min[r] = finish(acc_min[r]);
            fin_max[r] = finish(acc_max[r]);
            sat_next   = sat_next | fin_min[r][W] | fin_max[r][W];
        end
    end

    assign adv = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                min_reg[r] <= fin_min[r][W-1:0];
                max_reg[r] <= fin_max[r][W-1:0];
            end
            sat_reg <= sat_next;
        end
    end

    assign rsp.valid     = valid_reg;
    assign rsp.out_min_x = min_reg[0];
    assign rsp.out_min_y = min_reg[1];
    assign rsp.out_min_z = min_reg[2];
    assign rsp.out_max_x = max_reg[0];
    assign rsp.out_max_y = max_reg[1];
    assign rsp.out_max_z = max_reg[2];
    assign rsp.saturated = sat_reg;

endmodule

`default_nettype wire

/* hw/rtl/aabb_affine_transform.sv */
// Top level of the bounding box affine transform: matrix store, three lanes, merge.
// Depends on aabb_pkg, aabb_if, aabb_lane and aabb_merge.
//
// Takes one request per clock while req.ready is high. A load request (func 0)
// writes one row of the 3x4 matrix (three Q16.16 coefficients and a
// translation) and gives no response; a load to row 3 is dropped. A box
// request (func 1) returns the enclosing box of the eight transformed corners,
// rescaled with floor rounding and clamped to the coordinate width, with
// saturated set if any coordinate clamped. Each box uses the matrix as it
// stands when the box is accepted, so a load takes effect for the very next
// request. The response passes through three register stages: one stage of
// multipliers (six per row lane, three lanes), one stage of min/max selection
// and accumulation, and the saturating output register. After reset the
// matrix is the identity with zero translation. A stalled response holds only
// the stages behind it that are full; empty stages keep filling.
`default_nettype none

module aabb_affine_transform
    import aabb_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    aabb_req_if.sink   req,
    aabb_rsp_if.source rsp
);

    localparam int W  = COORD_WIDTH;
    localparam int AW = 2 * COORD_WIDTH + 2;

    logic signed [W-1:0]  coef_reg [NUM_ROWS][NUM_COLS];
    logic signed [W-1:0]  trans_reg [NUM_ROWS];
    logic signed [W-1:0]  box_lo [NUM_COLS];
    logic signed [W-1:0]  box_hi [NUM_COLS];
    logic signed [AW-1:0] acc_min [NUM_ROWS];
    logic signed [AW-1:0] acc_max [NUM_ROWS];
    logic                 v1_reg;
    logic                 v2_reg;
    logic                 adv1;
    logic                 adv2;
    logic                 adv3;
    logic                 load_fire;
    pipe_ctl_t            ctl;

    assign adv2      = !v2_reg || adv3;
    assign adv1      = !v1_reg || adv2;
    assign ctl.adv1  = adv1;
    assign ctl.adv2  = adv2;
    assign req.ready = adv1;
    assign load_fire = req.valid && req.ready && (req.func == FUNC_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                for (int c = 0; c < NUM_COLS; c++)
                    coef_reg[r][c] <= (r == c) ? (W'(1) <<< FRAC_BITS) : '0;
                trans_reg[r] <= '0;
            end
        end
        else if (load_fire)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                if (req.row == 2'(r))
                begin
                    coef_reg[r][0] <= req.val0;
                    coef_reg[r][1] <= req.val1;
                    coef_reg[r][2] <= req.val2;
                    trans_reg[r]   <= req.val3;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= req.valid && (req.func == FUNC_BOX);
            if (adv2)
                v2_reg <= v1_reg;
        end
    end

    assign box_lo[0] = req.val0;
    assign box_lo[1] = req.val1;
    assign box_lo[2] = req.val2;
    assign box_hi[0] = req.val3;
    assign box_hi[1] = req.val4;
    assign box_hi[2] = req.val5;

    for (genvar r = 0; r < NUM_ROWS; r++)
    begin : g_lane
        aabb_lane #(
            .W (COORD_WIDTH),
            .F (FRAC_BITS)
        ) u_lane (
            .clk     (clk),
            .ctl     (ctl),
            .coef    (coef_reg[r]),
            .trans   (trans_reg[r]),
            .lo      (box_lo),
            .hi      (box_hi),
            .acc_min (acc_min[r]),
            .acc_max (acc_max[r])
        );
    end

    aabb_merge #(
        .W (COORD_WIDTH),
        .F (FRAC_BITS)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v2_reg),
        .acc_min  (acc_min),
        .acc_max  (acc_max),
        .adv      (adv3),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

/* hw/rtl/aabb_check.sv */
// Port-level checks for the bounding box transform, bound to the top level.
// Depends on the top level aabb_affine_transform and its channel interfaces.
`default_nettype none

module aabb_check #(
    parameter int W = 32
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                rsp_valid,
    input wire logic                rsp_ready,
    input wire logic signed [W-1:0] out_min_x,
    input wire logic signed [W-1:0] out_min_y,
    input wire logic signed [W-1:0] out_min_z,
    input wire logic signed [W-1:0] out_max_x,
    input wire logic signed [W-1:0] out_max_y,
    input wire logic signed [W-1:0] out_max_z,
    input wire logic                saturated
);

    localparam logic signed [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

    logic no_bound;

    assign no_bound = (out_min_x != MAX_VAL) && (out_min_x != MIN_VAL)
                   && (out_min_y != MAX_VAL) && (out_min_y != MIN_VAL)
                   && (out_min_z != MAX_VAL) && (out_min_z != MIN_VAL)
                   && (out_max_x != MAX_VAL) && (out_max_x != MIN_VAL)
                   && (out_max_y != MAX_VAL) && (out_max_y != MIN_VAL)
                   && (out_max_z != MAX_VAL) && (out_max_z != MIN_VAL);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(out_min_x) && $stable(out_max_z)
                                    && $stable(saturated))
        else $error("stalled response changed");

    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (out_min_x <= out_max_x) && (out_min_y <= out_max_y)
                      && (out_min_z <= out_max_z))
        else $error("response box minimum above maximum");

    a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && no_bound |-> !saturated)
        else $error("saturated set with no clamped coordinate");

endmodule

bind aabb_affine_transform aabb_check #(
    .W (COORD_WIDTH)
) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .out_min_x (rsp.out_min_x),
    .out_min_y (rsp.out_min_y),
    .out_min_z (rsp.out_min_z),
    .out_max_x (rsp.out_max_x),
    .out_max_y (rsp.out_max_y),
    .out_max_z (rsp.out_max_z),
    .saturated (rsp.saturated)
);

`default_nettype wire

/* tb/aabb_transform_checker.sv */
// Checker for the bounding box affine transform: watches both channels,
// predicts each box response from its own matrix copy and compares fields.
// Depends on aabb_pkg and the request/response interfaces in aabb_if.
`timescale 1ns / 1ps

module aabb_transform_checker
    import aabb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    aabb_req_if  req,
    aabb_rsp_if  rsp,
    output int   fail_count,
    output int   pending_count
);

    localparam int FRAC = 16;
    localparam logic signed [79:0] COORD_MAX = 80'sh7FFF_FFFF;
    localparam logic signed [79:0] COORD_MIN = -80'sh8000_0000;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    typedef struct packed {
        logic [5:0][31:0] coord;
        logic             saturated;
    } box_result_t;

    logic signed [31:0] matrix [NUM_ROWS][4];
    box_result_t        expected_boxes [$];
    box_result_t        want;
    box_result_t        got;

    function automatic string coord_name(input int idx);
        case (idx)
            0: return "out_min_x";
            1: return "out_min_y";
            2: return "out_min_z";
            3: return "out_max_x";
            4: return "out_max_y";
            default: return "out_max_z";
        endcase
    endfunction

    // floor shift, then clamp to the coordinate range
    function automatic logic [32:0] rescale(input logic signed [79:0] acc);
        logic signed [79:0] v;
        v = acc >>> FRAC;
        if (v > COORD_MAX)
            return {1'b1, 32'h7FFF_FFFF};
        else if (v < COORD_MIN)
            return {1'b1, 32'h8000_0000};
        else
            return {1'b0, v[31:0]};
    endfunction

    function automatic box_result_t transform_box(input logic [2:0][31:0] lo,
                                                  input logic [2:0][31:0] hi);
        box_result_t        res;
        logic signed [79:0] acc_lo;
        logic signed [79:0] acc_hi;
        logic signed [79:0] p;
        logic signed [79:0] q;
        logic signed [79:0] t;
        logic [32:0]        fixed_lo;
        logic [32:0]        fixed_hi;
        res = '0;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            acc_lo = matrix[r][3];
            acc_lo = acc_lo <<< FRAC;
            acc_hi = acc_lo;
            for (int c = 0; c < NUM_COLS; c++)
            begin
                p = matrix[r][c] * $signed(lo[c]);
                q = matrix[r][c] * $signed(hi[c]);
                if (q < p)
                begin
                    t = p;
                    p = q;
                    q = t;
                end
                acc_lo = acc_lo + p;
                acc_hi = acc_hi + q;
            end
            fixed_lo = rescale(acc_lo);
            fixed_hi = rescale(acc_hi);
            res.coord[r]     = fixed_lo[31:0];
            res.coord[3 + r] = fixed_hi[31:0];
            res.saturated    = res.saturated | fixed_lo[32] | fixed_hi[32];
        end
        return res;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
                for (int c = 0; c < 4; c++)
                    matrix[r][c] = (r == c) ? ONE_Q16 : 32'h0;
            expected_boxes.delete();
            fail_count    = 0;
            pending_count <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_boxes.size() == 0)
                    note_failure("response with no box request outstanding");
                else
                begin
                    want = expected_boxes.pop_front();
                    got.coord = {rsp.out_max_z, rsp.out_max_y, rsp.out_max_x,
                                 rsp.out_min_z, rsp.out_min_y, rsp.out_min_x};
                    got.saturated = rsp.saturated;
                    for (int i = 0; i < 6; i++)
                        if (got.coord[i] !== want.coord[i])
                            note_failure($sformatf("%s expected %h got %h", coord_name(i),
                                                   want.coord[i], got.coord[i]));
                    if (got.saturated !== want.saturated)
                        note_failure($sformatf("saturated expected %b got %b",
                                               want.saturated, got.saturated));
                end
            end
            if (req.valid && req.ready)
            begin
                if (req.func == FUNC_BOX)
                    expected_boxes.push_back(transform_box({req.val2, req.val1, req.val0},
                                                           {req.val5, req.val4, req.val3}));
                else if (req.row < NUM_ROWS)
                begin
                    matrix[req.row][0] = req.val0;
                    matrix[req.row][1] = req.val1;
                    matrix[req.row][2] = req.val2;
                    matrix[req.row][3] = req.val3;
                end
            end
            pending_count <= expected_boxes.size();
        end
    end

endmodule

/* tb/tb_aabb_affine_transform.sv */
// Top of the bounding box transform testbench: clock, reset, request and
// response traffic with random gaps, and the final verdict.
// Depends on aabb_pkg, aabb_if, the block and aabb_transform_checker.
`timescale 1ns / 1ps

module tb_aabb_affine_transform;
    import aabb_pkg::*;

    localparam logic [1:0]  ROW_UNUSED = 2'd3;
    localparam logic [31:0] ONE_Q16    = 32'h0001_0000;
    localparam logic [31:0] NEG_ONE    = 32'hFFFF_0000;
    localparam logic [31:0] WORD_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN   = 32'h8000_0000;
    localparam int          NUM_RANDOM = 2000;

    logic clk = 1'b0;
    logic rst_n;
    logic quiet;
    int   fails;
    int   pending;

    aabb_req_if #(.W(32)) req ();
    aabb_rsp_if #(.W(32)) rsp ();

    aabb_affine_transform dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    aabb_transform_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .fail_count    (fails),
        .pending_count (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int idle_len();
        int k;
        k = $urandom_range(0, 99);
        if (quiet || k < 60)
            return 0;
        else if (k < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_coef();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45)
            return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        else if (k < 55)
        begin
            case ($urandom_range(0, 2))
                0: return ONE_Q16;
                1: return NEG_ONE;
                default: return 32'h0;
            endcase
        end
        else if (k < 70)
            return $urandom;
        else if (k < 85)
            return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        else
            return $urandom_range(0, 32'h0000_FFFF) - 32'h0000_8000;
    endfunction

    function automatic logic [31:0] rand_coord();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55)
            return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        else if (k < 70)
            return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
        else if (k < 85)
            return $urandom;
        else
        begin
            case ($urandom_range(0, 3))
                0: return WORD_MAX;
                1: return WORD_MIN;
                2: return 32'h0;
                default: return 32'hFFFF_FFFF;
            endcase
        end
    endfunction

    task automatic send_item(input logic f, input logic [1:0] r,
                             input logic [31:0] v0, input logic [31:0] v1,
                             input logic [31:0] v2, input logic [31:0] v3,
                             input logic [31:0] v4, input logic [31:0] v5);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            @(negedge clk);
            req.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req.valid <= 1'b1;
        req.func  <= f;
        req.row   <= r;
        req.val0  <= v0;
        req.val1  <= v1;
        req.val2  <= v2;
        req.val3  <= v3;
        req.val4  <= v4;
        req.val5  <= v5;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
    endtask

    // response side: runs of ready with random stalls between them
    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp.ready <= 1'b1;
            repeat ($urandom_range(0, 12)) @(negedge clk);
            stall = idle_len();
            if (stall > 0)
            begin
                @(negedge clk);
                rsp.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        req.valid = 1'b0;
        req.func  = FUNC_LOAD;
        req.row   = 2'd0;
        req.val0  = '0;
        req.val1  = '0;
        req.val2  = '0;
        req.val3  = '0;
        req.val4  = '0;
        req.val5  = '0;
        quiet     = 1'b1;
        rst_n     = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // identity matrix at the coordinate extremes, min above max, zero box
        send_item(FUNC_BOX, 2'd0, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX);
        send_item(FUNC_BOX, 2'd1, 32'h0005_0000, 32'hFFFD_0000, 32'h7, 32'hFFFF_FFF0,
                  32'hFFFC_0000, WORD_MIN);
        send_item(FUNC_BOX, 2'd2, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        // load to the unused row must be dropped
        send_item(FUNC_LOAD, ROW_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(FUNC_BOX, ROW_UNUSED, 32'h1234_5678, 32'hFEDC_BA98, 32'h0000_0001,
                  32'h7654_3210, 32'h89AB_CDEF, 32'hFFFF_FFFF);
        // extreme coefficients and translations: clamp both ways
        send_item(FUNC_LOAD, 2'd0, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX,
                  32'hAAAA_AAAA, 32'h5555_5555);
        send_item(FUNC_LOAD, 2'd1, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                  32'h5555_5555, 32'hAAAA_AAAA);
        send_item(FUNC_LOAD, 2'd2, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_item(FUNC_BOX, 2'd0, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX);
        send_item(FUNC_BOX, 2'd0, 32'h0000_0001, 32'h0000_0001, 32'h0, 32'h0000_0001,
                  32'h0000_0001, 32'h0);
        send_item(FUNC_BOX, 2'd1, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0);
        // quarter turn about z, half scale on z to check floor rounding
        send_item(FUNC_LOAD, 2'd0, 32'h0, NEG_ONE, 32'h0, 32'h0000_8000, 32'h0, 32'h0);
        send_item(FUNC_LOAD, 2'd1, ONE_Q16, 32'h0, 32'h0, 32'hFFFF_8000, 32'h0, 32'h0);
        send_item(FUNC_LOAD, 2'd2, 32'h0, 32'h0, 32'h0000_8000, 32'h0, 32'h0, 32'h0);
        send_item(FUNC_BOX, 2'd0, 32'hFFFF_FFFD, 32'h0000_0003, 32'hFFFF_FFFD,
                  32'h0000_0003, 32'hFFFF_FFFD, 32'h0000_0003);
        send_item(FUNC_BOX, 2'd2, 32'h0003_0000, 32'hFFF0_0001, WORD_MIN,
                  32'hFFFE_0000, 32'h0001_0001, WORD_MAX);
        // translation alone at the bounds
        send_item(FUNC_LOAD, 2'd0, 32'h0, 32'h0, 32'h0, WORD_MAX, 32'h0, 32'h0);
        send_item(FUNC_LOAD, 2'd1, 32'h0, 32'h0, 32'h0, WORD_MIN, 32'h0, 32'h0);
        send_item(FUNC_BOX, 2'd3, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MIN);
        // back to identity
        send_item(FUNC_LOAD, 2'd0, ONE_Q16, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(FUNC_LOAD, 2'd1, 32'h0, ONE_Q16, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(FUNC_LOAD, 2'd2, 32'h0, 32'h0, ONE_Q16, 32'h0, 32'h0, 32'h0);
        send_item(FUNC_BOX, 2'd1, 32'h8765_4321, 32'h0, 32'h7FFF_0000,
                  32'h0123_4567, 32'hFFFF_FFFF, 32'h8000_0001);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            quiet = ((i / 250) % 4) == 3;
            if ($urandom_range(0, 99) < 15)
                send_item(FUNC_LOAD, 2'($urandom_range(0, 3)), rand_coef(), rand_coef(),
                          rand_coef(), rand_coord(), $urandom, $urandom);
            else
                send_item(FUNC_BOX, 2'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end

        @(negedge clk);
        req.valid <= 1'b0;
        quiet = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
